// File: rtl/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg - shared types and constants of the source token lexer
// Token kinds, error codes, the result record and saturating counter helpers.
// ----------------------------------------------------------------------------
package stl_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int LINE_BITS   = 16;

    localparam int OFF_EXT  = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;
    localparam int LINE_EXT = (LINE_BITS > 16) ? LINE_BITS : 16;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};

    // token kinds
    localparam logic [3:0] KIND_STRING = 4'd0;
    localparam logic [3:0] KIND_ARROW  = 4'd1;
    localparam logic [3:0] KIND_COMMA  = 4'd2;
    localparam logic [3:0] KIND_SEMI   = 4'd3;
    localparam logic [3:0] KIND_LPAREN = 4'd4;
    localparam logic [3:0] KIND_RPAREN = 4'd5;
    localparam logic [3:0] KIND_FLOAT  = 4'd6;
    localparam logic [3:0] KIND_INT    = 4'd7;
    localparam logic [3:0] KIND_BOOL   = 4'd8;
    localparam logic [3:0] KIND_IDENT  = 4'd9;
    localparam logic [3:0] KIND_END    = 4'd10;

    // error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_LONE_MINUS = 3'd1;
    localparam logic [2:0] ERR_SECOND_DOT = 3'd2;
    localparam logic [2:0] ERR_UNTERM_STR = 3'd3;
    localparam logic [2:0] ERR_UNKNOWN_CH = 3'd4;

    typedef struct packed {
        logic [3:0]  kind;
        logic [2:0]  err;
        logic [15:0] line;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } result_t;

    // up to two results from one character
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } lex_out_t;

    function automatic logic [OFFSET_BITS-1:0] sat_inc_off(input logic [OFFSET_BITS-1:0] v);
        return (v == OFF_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [LINE_BITS-1:0] sat_inc_line(input logic [LINE_BITS-1:0] v);
        return (v == LINE_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [15:0] clip_off(input logic [OFFSET_BITS-1:0] v);
        logic [OFF_EXT-1:0] w;
        w = OFF_EXT'(v);
        return (w > OFF_EXT'(17'hFFFF)) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic [15:0] clip_line(input logic [LINE_BITS-1:0] v);
        logic [LINE_EXT-1:0] w;
        w = LINE_EXT'(v);
        return (w > LINE_EXT'(17'hFFFF)) ? 16'hFFFF : w[15:0];
    endfunction

endpackage

// File: rtl/stl_lex.sv
// ----------------------------------------------------------------------------
// stl_lex - lexer state and per-character decode
// Holds the scanning mode and counters; one character advances it per step.
// ----------------------------------------------------------------------------
module stl_lex (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [7:0]       ch,
    input  logic             end_mark,
    output stl_pkg::lex_out_t lex_out
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_STRING,
        MODE_MINUS,
        MODE_NUMBER,
        MODE_WORD,
        MODE_STOPPED
    } mode_t;

    // keyword prefix tracker: t,tr,tru,true and f,fa,fal,fals,false
    localparam logic [3:0] KW_NONE  = 4'd0;
    localparam logic [3:0] KW_T     = 4'd1;
    localparam logic [3:0] KW_TR    = 4'd2;
    localparam logic [3:0] KW_TRU   = 4'd3;
    localparam logic [3:0] KW_TRUE  = 4'd4;
    localparam logic [3:0] KW_F     = 4'd5;
    localparam logic [3:0] KW_FA    = 4'd6;
    localparam logic [3:0] KW_FAL   = 4'd7;
    localparam logic [3:0] KW_FALS  = 4'd8;
    localparam logic [3:0] KW_FALSE = 4'd9;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;

    mode_t                             mode_reg, mode_next;
    logic                              dot_reg, dot_next;
    logic [3:0]                        kw_reg, kw_next;
    logic [stl_pkg::LINE_BITS-1:0]     line_reg, line_next;
    logic [stl_pkg::OFFSET_BITS-1:0]   off_reg, off_next;
    logic [stl_pkg::OFFSET_BITS-1:0]   start_reg, start_next;
    logic [stl_pkg::OFFSET_BITS-1:0]   run_reg, run_next;

    logic                              fresh;
    logic                              pend_valid;
    logic [stl_pkg::OFFSET_BITS-1:0]   run_inc;
    stl_pkg::result_t                  pend_res;
    stl_pkg::result_t                  res0, res1;
    logic [1:0]                        cnt;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               (c == 8'h5F);
    endfunction

    function automatic logic [3:0] kw_step(input logic [3:0] s, input logic [7:0] c);
        logic [3:0] r;
        unique case (s)
            KW_T:    r = (c == 8'h72) ? KW_TR : KW_NONE;
            KW_TR:   r = (c == 8'h75) ? KW_TRU : KW_NONE;
            KW_TRU:  r = (c == 8'h65) ? KW_TRUE : KW_NONE;
            KW_F:    r = (c == 8'h61) ? KW_FA : KW_NONE;
            KW_FA:   r = (c == 8'h6C) ? KW_FAL : KW_NONE;
            KW_FAL:  r = (c == 8'h73) ? KW_FALS : KW_NONE;
            KW_FALS: r = (c == 8'h65) ? KW_FALSE : KW_NONE;
            default: r = KW_NONE;
        endcase
        return r;
    endfunction

    function automatic stl_pkg::result_t mk(
        input logic [3:0]                      kind,
        input logic [2:0]                      err,
        input logic [stl_pkg::LINE_BITS-1:0]   line,
        input logic [stl_pkg::OFFSET_BITS-1:0] start,
        input logic [stl_pkg::OFFSET_BITS-1:0] len
    );
        stl_pkg::result_t r;
        r.kind   = kind;
        r.err    = err;
        r.line   = stl_pkg::clip_line(line);
        r.start  = stl_pkg::clip_off(start);
        r.length = stl_pkg::clip_off(len);
        r.last   = 1'b0;
        return r;
    endfunction

    always_comb begin
        mode_next  = mode_reg;
        dot_next   = dot_reg;
        kw_next    = kw_reg;
        line_next  = line_reg;
        off_next   = off_reg;
        start_next = start_reg;
        run_next   = run_reg;
        res0       = '0;
        res1       = '0;
        cnt        = 2'd0;
        fresh      = 1'b0;
        run_inc    = stl_pkg::sat_inc_off(run_reg);
        pend_valid = (mode_reg == MODE_NUMBER) || (mode_reg == MODE_WORD);
        if (mode_reg == MODE_NUMBER) begin
            pend_res = mk(dot_reg ? stl_pkg::KIND_FLOAT : stl_pkg::KIND_INT,
                          stl_pkg::ERR_NONE, line_reg, start_reg, run_reg);
        end else begin
            pend_res = mk(((kw_reg == KW_TRUE) || (kw_reg == KW_FALSE)) ?
                          stl_pkg::KIND_BOOL : stl_pkg::KIND_IDENT,
                          stl_pkg::ERR_NONE, line_reg, start_reg, run_reg);
        end

        if (end_mark) begin
            unique case (mode_reg)
                MODE_STRING: begin
                    res0 = mk(stl_pkg::KIND_END, stl_pkg::ERR_UNTERM_STR, line_reg,
                              start_reg, run_reg);
                    cnt  = 2'd1;
                end
                MODE_MINUS: begin
                    res0 = mk(stl_pkg::KIND_END, stl_pkg::ERR_LONE_MINUS, line_reg,
                              start_reg, run_reg);
                    cnt  = 2'd1;
                end
                MODE_STOPPED: begin
                    cnt = 2'd0;
                end
                default: begin
                    if (pend_valid) begin
                        res0 = pend_res;
                        res1 = mk(stl_pkg::KIND_END, stl_pkg::ERR_NONE, line_reg, off_reg, '0);
                        cnt  = 2'd2;
                    end else begin
                        res0 = mk(stl_pkg::KIND_END, stl_pkg::ERR_NONE, line_reg, off_reg, '0);
                        cnt  = 2'd1;
                    end
                end
            endcase
            // restart for a new source
            mode_next  = MODE_IDLE;
            dot_next   = 1'b0;
            kw_next    = KW_NONE;
            line_next  = stl_pkg::LINE_BITS'(1);
            off_next   = '0;
            start_next = '0;
            run_next   = '0;
        end else begin
            unique case (mode_reg)
                MODE_STRING: begin
                    run_next = run_inc;
                    if (ch == CH_QUOTE) begin
                        res0      = mk(stl_pkg::KIND_STRING, stl_pkg::ERR_NONE, line_reg,
                                       start_reg, run_inc);
                        cnt       = 2'd1;
                        mode_next = MODE_IDLE;
                    end else if (ch == CH_NL) begin
                        line_next = stl_pkg::sat_inc_line(line_reg);
                    end
                end
                MODE_MINUS: begin
                    cnt = 2'd1;
                    if (ch == CH_GT) begin
                        res0      = mk(stl_pkg::KIND_ARROW, stl_pkg::ERR_NONE, line_reg,
                                       start_reg, stl_pkg::OFFSET_BITS'(2));
                        mode_next = MODE_IDLE;
                    end else begin
                        res0      = mk(stl_pkg::KIND_END, stl_pkg::ERR_LONE_MINUS, line_reg,
                                       start_reg, run_reg);
                        mode_next = MODE_STOPPED;
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit(ch)) begin
                        run_next = run_inc;
                    end else if (ch == CH_DOT) begin
                        if (dot_reg) begin
                            res0      = mk(stl_pkg::KIND_END, stl_pkg::ERR_SECOND_DOT,
                                           line_reg, start_reg, run_reg);
                            cnt       = 2'd1;
                            mode_next = MODE_STOPPED;
                        end else begin
                            dot_next = 1'b1;
                            run_next = run_inc;
                        end
                    end else begin
                        res0      = pend_res;
                        cnt       = 2'd1;
                        mode_next = MODE_IDLE;
                        fresh     = 1'b1;
                    end
                end
                MODE_WORD: begin
                    if (is_letter(ch)) begin
                        kw_next  = kw_step(kw_reg, ch);
                        run_next = run_inc;
                    end else begin
                        res0      = pend_res;
                        cnt       = 2'd1;
                        mode_next = MODE_IDLE;
                        fresh     = 1'b1;
                    end
                end
                MODE_IDLE: begin
                    fresh = 1'b1;
                end
                default: begin
                    // stopped: drop characters until the end item
                end
            endcase

            if (fresh) begin
                priority if (ch == CH_SPACE) begin
                end else if (ch == CH_NL) begin
                    line_next = stl_pkg::sat_inc_line(line_reg);
                end else if (ch == CH_QUOTE || ch == CH_MINUS || is_digit(ch) ||
                             is_letter(ch)) begin
                    start_next = off_reg;
                    run_next   = stl_pkg::OFFSET_BITS'(1);
                    dot_next   = 1'b0;
                    if (ch == CH_QUOTE) begin
                        mode_next = MODE_STRING;
                    end else if (ch == CH_MINUS) begin
                        mode_next = MODE_MINUS;
                    end else if (is_digit(ch)) begin
                        mode_next = MODE_NUMBER;
                    end else begin
                        mode_next = MODE_WORD;
                        kw_next   = (ch == 8'h74) ? KW_T : ((ch == 8'h66) ? KW_F : KW_NONE);
                    end
                end else begin
                    if (cnt == 2'd0) begin
                        cnt = 2'd1;
                        priority if (ch == CH_COMMA) begin
                            res0 = mk(stl_pkg::KIND_COMMA, stl_pkg::ERR_NONE, line_reg,
                                      off_reg, stl_pkg::OFFSET_BITS'(1));
                        end else if (ch == CH_SEMI) begin
                            res0 = mk(stl_pkg::KIND_SEMI, stl_pkg::ERR_NONE, line_reg,
                                      off_reg, stl_pkg::OFFSET_BITS'(1));
                        end else if (ch == CH_LPAR) begin
                            res0 = mk(stl_pkg::KIND_LPAREN, stl_pkg::ERR_NONE, line_reg,
                                      off_reg, stl_pkg::OFFSET_BITS'(1));
                        end else if (ch == CH_RPAR) begin
                            res0 = mk(stl_pkg::KIND_RPAREN, stl_pkg::ERR_NONE, line_reg,
                                      off_reg, stl_pkg::OFFSET_BITS'(1));
                        end else begin
                            res0 = mk(stl_pkg::KIND_END, stl_pkg::ERR_UNKNOWN_CH, line_reg,
                                      off_reg, stl_pkg::OFFSET_BITS'(1));
                        end
                    end else begin
                        cnt = 2'd2;
                        priority if (ch == CH_COMMA) begin
                            res1 = mk(stl_pkg::KIND_COMMA, stl_pkg::ERR_NONE, line_reg,
                                      off_reg, stl_pkg::OFFSET_BITS'(1));
                        end else if (ch == CH_SEMI) begin
                            res1 = mk(stl_pkg::KIND_SEMI, stl_pkg::ERR_NONE, line_reg,
                                      off_reg, stl_pkg::OFFSET_BITS'(1));
                        end else if (ch == CH_LPAR) begin
                            res1 = mk(stl_pkg::KIND_LPAREN, stl_pkg::ERR_NONE, line_reg,
                                      off_reg, stl_pkg::OFFSET_BITS'(1));
                        end else if (ch == CH_RPAR) begin
                            res1 = mk(stl_pkg::KIND_RPAREN, stl_pkg::ERR_NONE, line_reg,
                                      off_reg, stl_pkg::OFFSET_BITS'(1));
                        end else begin
                            res1 = mk(stl_pkg::KIND_END, stl_pkg::ERR_UNKNOWN_CH, line_reg,
                                      off_reg, stl_pkg::OFFSET_BITS'(1));
                        end
                    end
                    if (!(ch == CH_COMMA || ch == CH_SEMI || ch == CH_LPAR ||
                          ch == CH_RPAR)) begin
                        mode_next = MODE_STOPPED;
                    end
                end
            end
            off_next = stl_pkg::sat_inc_off(off_reg);
        end

        // mark the final result of this character
        res0.last = (cnt == 2'd1);
        res1.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            dot_reg   <= 1'b0;
            kw_reg    <= KW_NONE;
            line_reg  <= stl_pkg::LINE_BITS'(1);
            off_reg   <= '0;
            start_reg <= '0;
            run_reg   <= '0;
        end else if (step) begin
            mode_reg  <= mode_next;
            dot_reg   <= dot_next;
            kw_reg    <= kw_next;
            line_reg  <= line_next;
            off_reg   <= off_next;
            start_reg <= start_next;
            run_reg   <= run_next;
        end
    end

    assign lex_out.cnt = cnt;
    assign lex_out.r0  = res0;
    assign lex_out.r1  = res1;

endmodule

// File: rtl/stl_resq.sv
// ----------------------------------------------------------------------------
// stl_resq - result queue
// Four-entry queue of result records; takes up to two per cycle, gives one.
// ----------------------------------------------------------------------------
module stl_resq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  stl_pkg::lex_out_t push_data,
    input  logic              pop,
    output logic              room2,
    output logic              head_valid,
    output stl_pkg::result_t  head
);

    stl_pkg::result_t q_reg [4];
    logic [1:0]       wr_ptr_reg, wr_ptr_next;
    logic [1:0]       rd_ptr_reg, rd_ptr_next;
    logic [2:0]       count_reg, count_next;
    logic [1:0]       n_push;
    logic             do_pop;

    assign n_push     = push ? push_data.cnt : 2'd0;
    assign do_pop     = pop && (count_reg != 3'd0);
    assign room2      = (count_reg <= 3'd2);
    assign head_valid = (count_reg != 3'd0);
    assign head       = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + n_push;
        rd_ptr_next = rd_ptr_reg + {1'b0, do_pop};
        count_next  = count_reg + {1'b0, n_push} - {2'b00, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            q_reg[wr_ptr_reg] <= push_data.r0;
        end
        if (n_push == 2'd2) begin
            q_reg[wr_ptr_reg + 2'd1] <= push_data.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/source_token_lexer_top.sv
// ----------------------------------------------------------------------------
// source_token_lexer_top - streaming source token lexer
// Character stream in, token records (kind, error, line, start, length) out.
// ----------------------------------------------------------------------------
// One source character enters per transaction; the end of the source is a
// transaction with s_axis_tuser high, whose character is ignored. Each
// character is registered, decoded combinationally by the lexer and yields
// zero, one or two token records, which wait in a four-entry result queue;
// m_axis_tlast marks the last record caused by one character. The lexer
// takes one character per clock while the queue holds at most two records,
// so one character a cycle is sustained whenever the consumer takes one
// record a cycle; characters that close a number or word and also form a
// token of their own yield two records. A transaction passes the input
// register and then the result queue. After an error record the
// lexer drops characters until the end item, which then yields nothing.
// Line, start and length saturate at 65535.
module source_token_lexer_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input character stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic [0:0]  s_axis_tuser,   // [0] end_mark
    // token record stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] line_number, [31:16] token_start,
                                        // [47:32] token_length
    output logic [6:0]  m_axis_tuser,   // [3:0] token_kind, [6:4] error_code
    output logic        m_axis_tlast    // last_result
);

    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_ch_reg;
    logic              in_end_reg;
    logic              s_accept;
    logic              proceed;
    logic              room2;
    logic              head_valid;
    stl_pkg::result_t  head;
    stl_pkg::lex_out_t lex_out;

    // decode the held character once the queue can take two records
    assign proceed       = in_valid_reg && room2;
    assign s_axis_tready = !in_valid_reg || proceed;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (proceed) begin
            in_valid_next = 1'b0;
        end
    end

    // input register: hold the character until the lexer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_ch_reg  <= s_axis_tdata;
            in_end_reg <= s_axis_tuser[0];
        end
    end

    stl_lex u_lex (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (proceed),
        .ch       (in_ch_reg),
        .end_mark (in_end_reg),
        .lex_out  (lex_out)
    );

    stl_resq u_resq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (proceed),
        .push_data  (lex_out),
        .pop        (m_axis_tready),
        .room2      (room2),
        .head_valid (head_valid),
        .head       (head)
    );

    // present the queue head
    assign m_axis_tvalid = head_valid;
    assign m_axis_tdata  = {head.length, head.start, head.line};
    assign m_axis_tuser  = {head.err, head.kind};
    assign m_axis_tlast  = head.last;

`ifndef SYNTH
    // errors only ride on end-kind records
    a_err_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser[6:4] != stl_pkg::ERR_NONE)) |->
        (m_axis_tuser[3:0] == stl_pkg::KIND_END))
        else $error("error code on a non-end token");

    // an error record always closes its character's results
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser[6:4] != stl_pkg::ERR_NONE)) |-> m_axis_tlast)
        else $error("error record not last of its transaction");

    // a clean end token is empty and last
    a_end_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser[3:0] == stl_pkg::KIND_END) &&
         (m_axis_tuser[6:4] == stl_pkg::ERR_NONE)) |->
        ((m_axis_tdata[47:32] == 16'd0) && m_axis_tlast))
        else $error("end token with nonzero length or not last");
`endif

endmodule

// File: tb/source_token_lexer_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// source_token_lexer_top_test - self-checking bench for the source token lexer
// Streams directed and random source text into the lexer. A token
// predictor runs on every accepted character and queues the token
// records it implies. A monitor checks every record leaving the block against
// that queue.
// ----------------------------------------------------------------------------
module source_token_lexer_top_test;
    import stl_pkg::*;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int RANDOM_CHARS = 810;

    // character codes the lexer treats specially
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_GT    = 8'h3E;

    // keyword prefix tracker states
    localparam logic [3:0] KW_NONE  = 4'd0;
    localparam logic [3:0] KW_T     = 4'd1;
    localparam logic [3:0] KW_TR    = 4'd2;
    localparam logic [3:0] KW_TRU   = 4'd3;
    localparam logic [3:0] KW_TRUE  = 4'd4;
    localparam logic [3:0] KW_F     = 4'd5;
    localparam logic [3:0] KW_FA    = 4'd6;
    localparam logic [3:0] KW_FAL   = 4'd7;
    localparam logic [3:0] KW_FALS  = 4'd8;
    localparam logic [3:0] KW_FALSE = 4'd9;

    typedef enum logic [2:0] {
        LX_IDLE, LX_STRING, LX_MINUS, LX_NUMBER, LX_WORD, LX_STOPPED
    } lex_mode_e;

    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
        logic       hold;   // wait for every expected token before sending
    } src_char_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic [0:0]  s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [6:0]  m_axis_tuser;
    logic        m_axis_tlast;

    src_char_t pending_chars[$];
    result_t   tokens_expected[$];
    result_t   step_tokens[$];
    bit        hold_next;
    int        mismatch_count = 0;
    int        cycles = 0;
    logic      calm;

    // predictor state
    lex_mode_e              pm_mode;
    logic                   pm_dot;
    logic [3:0]             pm_kw;
    logic [LINE_BITS-1:0]   pm_line;
    logic [OFFSET_BITS-1:0] pm_offset;
    logic [OFFSET_BITS-1:0] pm_start;
    logic [OFFSET_BITS-1:0] pm_len;

    source_token_lexer_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 aclk = ~aclk;

    // Long stretches with no idling on either side, three tenths of the time.
    assign calm = (cycles % 1000) >= 700;

    // ------------------------------------------------------------------
    // Token predictor
    // ------------------------------------------------------------------
    function automatic logic [OFFSET_BITS-1:0] off_inc(input logic [OFFSET_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [15:0] sat16(input logic [31:0] v);
        return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

    // advance the true/false prefix tracker by one letter
    function automatic logic [3:0] kw_advance(input logic [3:0] s, input logic [7:0] c);
        case (s)
            KW_T:    return (c == 8'h72) ? KW_TR    : KW_NONE;
            KW_TR:   return (c == 8'h75) ? KW_TRU   : KW_NONE;
            KW_TRU:  return (c == 8'h65) ? KW_TRUE  : KW_NONE;
            KW_F:    return (c == 8'h61) ? KW_FA    : KW_NONE;
            KW_FA:   return (c == 8'h6C) ? KW_FAL   : KW_NONE;
            KW_FAL:  return (c == 8'h73) ? KW_FALS  : KW_NONE;
            KW_FALS: return (c == 8'h65) ? KW_FALSE : KW_NONE;
            default: return KW_NONE;
        endcase
    endfunction

    task automatic add_token(input logic [3:0] kind, input logic [2:0] err,
                             input logic [OFFSET_BITS-1:0] start,
                             input logic [OFFSET_BITS-1:0] len);
        result_t r;
        r.kind   = kind;
        r.err    = err;
        r.line   = sat16(32'(pm_line));
        r.start  = sat16(32'(start));
        r.length = sat16(32'(len));
        r.last   = 1'b0;
        step_tokens.push_back(r);
    endtask

    // close an open number or word
    task automatic flush_run();
        if (pm_mode == LX_NUMBER) begin
            add_token(pm_dot ? KIND_FLOAT : KIND_INT, ERR_NONE, pm_start, pm_len);
        end else if (pm_mode == LX_WORD) begin
            add_token((pm_kw == KW_TRUE || pm_kw == KW_FALSE) ? KIND_BOOL : KIND_IDENT,
                      ERR_NONE, pm_start, pm_len);
        end
    endtask

    task automatic open_run(input lex_mode_e m);
        pm_mode  = m;
        pm_start = pm_offset;
        pm_len   = OFFSET_BITS'(1);
        pm_dot   = 1'b0;
    endtask

    task automatic lexer_restart();
        pm_mode   = LX_IDLE;
        pm_dot    = 1'b0;
        pm_kw     = KW_NONE;
        pm_line   = LINE_BITS'(1);
        pm_offset = '0;
        pm_start  = '0;
        pm_len    = '0;
    endtask

    task automatic lex_predict(input logic [7:0] c, input logic eos);
        bit fresh;
        fresh = 1'b0;
        step_tokens.delete();
        if (eos) begin
            case (pm_mode)
                LX_STRING:  add_token(KIND_END, ERR_UNTERM_STR, pm_start, pm_len);
                LX_MINUS:   add_token(KIND_END, ERR_LONE_MINUS, pm_start, pm_len);
                LX_STOPPED: ;
                default: begin
                    flush_run();
                    add_token(KIND_END, ERR_NONE, pm_offset, '0);
                end
            endcase
            lexer_restart();
        end else begin
            case (pm_mode)
                LX_STRING: begin
                    pm_len = off_inc(pm_len);
                    if (c == CH_QUOTE) begin
                        add_token(KIND_STRING, ERR_NONE, pm_start, pm_len);
                        pm_mode = LX_IDLE;
                    end else if (c == CH_NL) begin
                        pm_line = line_inc(pm_line);
                    end
                end
                LX_MINUS: begin
                    if (c == CH_GT) begin
                        add_token(KIND_ARROW, ERR_NONE, pm_start, OFFSET_BITS'(2));
                        pm_mode = LX_IDLE;
                    end else begin
                        add_token(KIND_END, ERR_LONE_MINUS, pm_start, pm_len);
                        pm_mode = LX_STOPPED;
                    end
                end
                LX_NUMBER: begin
                    if (is_digit(c)) begin
                        pm_len = off_inc(pm_len);
                    end else if (c == CH_DOT) begin
                        if (pm_dot) begin
                            add_token(KIND_END, ERR_SECOND_DOT, pm_start, pm_len);
                            pm_mode = LX_STOPPED;
                        end else begin
                            pm_dot = 1'b1;
                            pm_len = off_inc(pm_len);
                        end
                    end else begin
                        flush_run();
                        pm_mode = LX_IDLE;
                        fresh   = 1'b1;
                    end
                end
                LX_WORD: begin
                    if (is_letter(c)) begin
                        pm_kw  = kw_advance(pm_kw, c);
                        pm_len = off_inc(pm_len);
                    end else begin
                        flush_run();
                        pm_mode = LX_IDLE;
                        fresh   = 1'b1;
                    end
                end
                LX_IDLE: fresh = 1'b1;
                default: ;
            endcase

            // the terminating character of a run is lexed in its own right
            if (fresh) begin
                case (c)
                    CH_SPACE: ;
                    CH_NL:    pm_line = line_inc(pm_line);
                    CH_QUOTE: open_run(LX_STRING);
                    CH_MINUS: open_run(LX_MINUS);
                    CH_COMMA: add_token(KIND_COMMA,  ERR_NONE, pm_offset, OFFSET_BITS'(1));
                    CH_SEMI:  add_token(KIND_SEMI,   ERR_NONE, pm_offset, OFFSET_BITS'(1));
                    CH_LPAR:  add_token(KIND_LPAREN, ERR_NONE, pm_offset, OFFSET_BITS'(1));
                    CH_RPAR:  add_token(KIND_RPAREN, ERR_NONE, pm_offset, OFFSET_BITS'(1));
                    default: begin
                        if (is_digit(c)) begin
                            open_run(LX_NUMBER);
                        end else if (is_letter(c)) begin
                            open_run(LX_WORD);
                            pm_kw = (c == 8'h74) ? KW_T : ((c == 8'h66) ? KW_F : KW_NONE);
                        end else begin
                            add_token(KIND_END, ERR_UNKNOWN_CH, pm_offset, OFFSET_BITS'(1));
                            pm_mode = LX_STOPPED;
                        end
                    end
                endcase
            end
            pm_offset = off_inc(pm_offset);
        end

        if (step_tokens.size() != 0)
            step_tokens[step_tokens.size()-1].last = 1'b1;
        foreach (step_tokens[i])
            tokens_expected.push_back(step_tokens[i]);
    endtask

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    task automatic add_char(input logic [7:0] c);
        src_char_t s;
        s.ch   = c;
        s.eos  = 1'b0;
        s.hold = hold_next;
        hold_next = 1'b0;
        pending_chars.push_back(s);
    endtask

    task automatic add_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            add_char(txt[i]);
    endtask

    task automatic add_end(input logic [7:0] c);
        src_char_t s;
        s.ch   = c;
        s.eos  = 1'b1;
        s.hold = hold_next;
        hold_next = 1'b0;
        pending_chars.push_back(s);
    endtask

    task automatic add_digits(input int n);
        repeat (n) add_char(8'h30 + 8'($urandom_range(0, 9)));
    endtask

    task automatic add_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)      add_char(8'h61 + 8'(r));
        else if (r < 52) add_char(8'h41 + 8'(r - 26));
        else             add_char(8'h5F);
    endtask

    // one random source: mostly well-formed tokens, some noise and breakage
    task automatic gen_source();
        int ntok, pick, len;
        logic [7:0] b;
        hold_next = ($urandom_range(0, 9) == 0);
        ntok = $urandom_range(1, 10);
        for (int k = 0; k < ntok; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                add_char(CH_QUOTE);
                len = $urandom_range(0, 6);
                repeat (len) begin
                    b = 8'($urandom_range(0, 255));
                    add_char(b == CH_QUOTE ? CH_NL : b);
                end
                add_char(CH_QUOTE);
            end else if (pick < 18) begin
                add_text("->");
            end else if (pick < 32) begin
                case ($urandom_range(0, 3))
                    0: add_char(CH_COMMA);
                    1: add_char(CH_SEMI);
                    2: add_char(CH_LPAR);
                    default: add_char(CH_RPAR);
                endcase
            end else if (pick < 46) begin
                add_digits($urandom_range(1, 5));
            end else if (pick < 56) begin
                add_digits($urandom_range(1, 3));
                add_char(CH_DOT);
                add_digits($urandom_range(0, 3));
            end else if (pick < 66) begin
                case ($urandom_range(0, 6))
                    0: add_text("true");
                    1: add_text("false");
                    2: add_text("tru");
                    3: add_text("fals");
                    4: add_text("trueish");
                    5: add_text("f");
                    default: add_text("t");
                endcase
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 6)) add_letter();
            end else if (pick < 92) begin
                add_char(8'($urandom_range(0, 255)));
            end else if (pick < 94) begin
                add_char(CH_MINUS);
                add_char(8'($urandom_range(0, 255)));
            end else if (pick < 96) begin
                add_text("3.1.4");
            end else if (pick < 97) begin
                // leave a string open at the end of the source
                add_char(CH_QUOTE);
                add_text("open");
                break;
            end
            case ($urandom_range(0, 5))
                2, 3: add_char(CH_SPACE);
                4:    add_char(CH_NL);
                5:    add_text("  ");
                default: ;
            endcase
        end
        add_end(8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // Driver: present queued characters, predict each accepted transaction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                lex_predict(s_axis_tdata, s_axis_tuser[0]);
            // hold the current transaction until it is taken
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_chars.size() != 0 && (calm || $urandom_range(0, 99) >= 12) &&
                    !(pending_chars[0].hold && tokens_expected.size() != 0)) begin
                    s_axis_tvalid   <= 1'b1;
                    s_axis_tdata    <= pending_chars[0].ch;
                    s_axis_tuser[0] <= pending_chars[0].eos;
                    void'(pending_chars.pop_front());
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each token record with the oldest prediction
    // ------------------------------------------------------------------
    task automatic report_bad(input bit have_want, input result_t want, input result_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            if (have_want)
                $display("mismatch: expected kind %0d err %0d line %0d start %0d len %0d last %0d",
                         want.kind, want.err, want.line, want.start, want.length, want.last);
            else
                $display("mismatch: no token expected");
            $display("          got      kind %0d err %0d line %0d start %0d len %0d last %0d",
                     got.kind, got.err, got.line, got.start, got.length, got.last);
        end
    endtask

    always @(posedge aclk) begin
        result_t got, want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind   = m_axis_tuser[3:0];
                got.err    = m_axis_tuser[6:4];
                got.line   = m_axis_tdata[15:0];
                got.start  = m_axis_tdata[31:16];
                got.length = m_axis_tdata[47:32];
                got.last   = m_axis_tlast;
                if (tokens_expected.size() == 0) begin
                    report_bad(1'b0, got, got);
                end else begin
                    want = tokens_expected.pop_front();
                    if (got !== want)
                        report_bad(1'b1, want, got);
                end
            end
            m_axis_tready <= calm || $urandom_range(0, 99) >= 12;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int first_random;
        lexer_restart();

        // directed: every token kind, runs closed by a token of their own,
        // then each error; mid-source ones get stopped input and a silent end
        hold_next = 1'b1;
        add_text("\"a\n\"->,;(7)2.5 true,x");
        add_end(8'h00);
        // wait for the first source's tokens before the error cases
        hold_next = 1'b1;
        add_text("-,;");
        add_end(8'hFF);
        add_text("1..9");
        add_end(8'h2E);
        add_text("\"q");
        add_end(8'h22);
        add_char(8'h00);
        add_end(8'h41);
        add_char(CH_MINUS);
        add_end(8'h3E);

        // random sources
        first_random = pending_chars.size();
        while (pending_chars.size() < first_random + RANDOM_CHARS)
            gen_source();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // drain the input queue, then every expected token
        while (pending_chars.size() != 0 || s_axis_tvalid) @(posedge aclk);
        while (tokens_expected.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        if (mismatch_count == 0 && tokens_expected.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/stl_pkg.sv
rtl/stl_lex.sv
rtl/stl_resq.sv
rtl/source_token_lexer_top.sv
tb/source_token_lexer_top_test.sv
